// ----- hdl/clce_pkg.sv -----
// Shared types and constants for the circular list cursor engine.
// No dependencies; imported by the top level.
package clce_pkg;

    localparam int DATA_W = 32;

    // command carried by each input item
    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    // error code carried by each result item
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

endpackage

// ----- hdl/clce_skid.sv -----
// Two-entry output skid buffer for the circular list cursor engine.
// Generic payload vector; no package dependencies.
module clce_skid #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [1:0]       r_count;
    logic [WIDTH-1:0] r_data0;
    logic [WIDTH-1:0] r_data1;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_count <= r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    // hold the head item, shift the second one forward on a pop
    always_ff @(posedge i_clk) begin
        if (r_count == 2'd0 || (r_count == 2'd1 && w_pop)) begin
            if (w_push) begin
                r_data0 <= i_data;
            end
        end else if (r_count == 2'd1) begin
            if (w_push) begin
                r_data1 <= i_data;
            end
        end else if (w_pop) begin
            r_data0 <= r_data1;
        end
    end

endmodule

// ----- hdl/circular_list_cursor_engine_top.sv -----
// A result item is registered in the output skid buffer and offered once any
// earlier result has been taken. One item is accepted per cycle while that buffer
// has room; the cached cursor neighbourhood and prefetched reads avoid memory waits.
// Reset (synchronous, active low) empties the list and the output buffer at
// once; node storage holds undefined contents until written, no clearing pass.
module circular_list_cursor_engine_top
    import clce_pkg::*;
#(
    parameter int POOL_NODES = 16,
    localparam int IDX_W = $clog2(POOL_NODES),
    localparam int CNT_W = $clog2(POOL_NODES + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_insert_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_back_value,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic                     o_list_empty,
    output logic [CNT_W-1:0]         o_node_count,
    output logic [1:0]               o_error_code
);

    localparam int RES_W = 2 * DATA_W + 1 + CNT_W + 2;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_NODES);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // list state; front is the node after the cursor, front2 the one after it
    logic [CNT_W-1:0]         r_size, n_size;
    logic [CNT_W-1:0]         r_max, n_max;
    logic [IDX_W-1:0]         r_cur, n_cur;
    logic [IDX_W-1:0]         r_front, n_front;
    logic [IDX_W-1:0]         r_front2, n_front2;
    logic signed [DATA_W-1:0] r_bval, n_bval;
    logic signed [DATA_W-1:0] r_fval, n_fval;

    // node pool and free stack; the cursor's next entry lives in r_front
    logic signed [DATA_W-1:0] mem_value [POOL_NODES];
    logic [IDX_W-1:0]         mem_next  [POOL_NODES];
    logic [IDX_W-1:0]         mem_free  [POOL_NODES];
    logic signed [DATA_W-1:0] r_rd_val;
    logic [IDX_W-1:0]         r_rd_next;
    logic [IDX_W-1:0]         r_rd_free;

    logic             val_we;
    logic             next_we;
    logic [IDX_W-1:0] next_waddr;
    logic [IDX_W-1:0] next_wdata;
    logic             free_we;
    logic [IDX_W-1:0] push_slot;
    logic [CNT_W-1:0] push_wide;
    logic [CNT_W-1:0] top_wide;
    logic [IDX_W-1:0] n_top;
    logic [IDX_W-1:0] n_node;
    logic [IDX_W-1:0] adv_f2;
    logic [IDX_W-1:0] rem_f2;
    logic             accept;
    t_err             err;
    logic             res_empty;
    logic [RES_W-1:0] res_data;
    logic [RES_W-1:0] out_data;

    assign accept = i_in_valid && o_in_ready;

    // node taken from the free stack: at or above the high-water mark no fresh slot
    // has been used yet, so the node index is the list size itself
    assign n_node = (r_size >= r_max) ? r_size[IDX_W-1:0] : r_rd_free;

    // take front2's link from cached state instead of the prefetch when front2 is the cursor
    assign adv_f2 = (r_front2 == r_cur) ? r_front : r_rd_next;
    assign rem_f2 = (r_front2 == r_cur) ? r_front2 : r_rd_next;

    // free stack slot for a removed node
    assign push_wide = FULL_CNT - r_size;
    assign push_slot = push_wide[IDX_W-1:0];

    // next state and result for one item
    always_comb begin
        n_size     = r_size;
        n_max      = r_max;
        n_cur      = r_cur;
        n_front    = r_front;
        n_front2   = r_front2;
        n_bval     = r_bval;
        n_fval     = r_fval;
        val_we     = 1'b0;
        next_we    = 1'b0;
        next_waddr = r_cur;
        next_wdata = r_front;
        free_we    = 1'b0;
        err        = ERR_OK;
        if (accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_ADVANCE: begin
                    if (r_size == '0) begin
                        err = ERR_EMPTY;
                    end else begin
                        n_cur      = r_front;
                        n_front    = r_front2;
                        n_front2   = adv_f2;
                        n_bval     = r_fval;
                        n_fval     = r_rd_val;
                        next_we    = 1'b1;
                        next_waddr = r_cur;
                        next_wdata = r_front;
                    end
                end
                CMD_INSERT: begin
                    if (r_size == FULL_CNT) begin
                        err = ERR_FULL;
                    end else begin
                        val_we     = 1'b1;
                        next_we    = 1'b1;
                        next_waddr = n_node;
                        n_size     = r_size + ONE_CNT;
                        if (r_size >= r_max) begin
                            n_max = r_size + ONE_CNT;
                        end
                        if (r_size == '0) begin
                            next_wdata = n_node;
                            n_cur      = n_node;
                            n_front    = n_node;
                            n_front2   = n_node;
                            n_bval     = i_insert_value;
                            n_fval     = i_insert_value;
                        end else begin
                            next_wdata = r_front;
                            n_front    = n_node;
                            n_front2   = r_front;
                            n_fval     = i_insert_value;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (r_size == '0) begin
                        err = ERR_EMPTY;
                    end else begin
                        free_we = 1'b1;
                        n_size  = r_size - ONE_CNT;
                        if (r_size == ONE_CNT) begin
                            n_cur = '0;
                        end else begin
                            n_front  = r_front2;
                            n_front2 = rem_f2;
                            n_fval   = r_rd_val;
                        end
                    end
                end
                CMD_READ: begin
                end
            endcase
        end
    end

    // free stack top for the size after this item
    always_comb begin
        top_wide = FULL_CNT - ONE_CNT - n_size;
        n_top    = (n_size < FULL_CNT) ? top_wide[IDX_W-1:0] : '0;
    end

    // pack the result item
    assign res_empty = (n_size == '0);
    assign res_data  = {res_empty ? '0 : n_bval,
                        res_empty ? '0 : n_fval,
                        res_empty, n_size, err};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_max  <= '0;
            r_cur  <= '0;
        end else begin
            r_size <= n_size;
            r_max  <= n_max;
            r_cur  <= n_cur;
        end
    end

    // cached neighbourhood of the cursor
    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_front2 <= n_front2;
        r_bval   <= n_bval;
        r_fval   <= n_fval;
    end

    // node values: write on insert, prefetch at the next front2
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            mem_value[n_node] <= i_insert_value;
        end
        r_rd_val <= (val_we && n_node == n_front2) ? i_insert_value : mem_value[n_front2];
    end

    // node links: write on insert or advance, prefetch at the next front2
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            mem_next[next_waddr] <= next_wdata;
        end
        r_rd_next <= (next_we && next_waddr == n_front2) ? next_wdata : mem_next[n_front2];
    end

    // free stack: push the removed node, prefetch the next top
    always_ff @(posedge i_clk) begin
        if (free_we) begin
            mem_free[push_slot] <= r_front;
        end
        r_rd_free <= (free_we && push_slot == n_top) ? r_front : mem_free[n_top];
    end

    // decouple the result side
    clce_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (res_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_back_value  = out_data[RES_W-1 -: DATA_W];
    assign o_front_value = out_data[RES_W-1-DATA_W -: DATA_W];
    assign o_list_empty  = out_data[CNT_W + 2];
    assign o_node_count  = out_data[CNT_W+1 -: CNT_W];
    assign o_error_code  = out_data[1:0];

`ifndef SYNTHESIS
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= FULL_CNT)
        else $error("list size beyond pool");

    a_mark_covers_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max >= r_size)
        else $error("free stack high-water mark below list size");

    a_empty_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size == '0) |-> (r_cur == '0))
        else $error("cursor not at zero on empty list");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_INSERT && r_size == FULL_CNT) |=>
        (r_size == $past(r_size) && r_cur == $past(r_cur)))
        else $error("insert into full pool changed state");

    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_size == '0 && (i_cmd == CMD_ADVANCE || i_cmd == CMD_REMOVE))
        |=> (r_size == '0))
        else $error("command on empty list changed size");
`endif

endmodule
